FILE: src/ctn_pkg.sv
// ----------------------------------------------------------------------------
// ctn_pkg
// Shared constants, control word types, microcode table and calendar helper
// functions for the calendar time normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctn_pkg;

  localparam int FieldWidthDefault = 32;

  // Port field widths
  localparam int RawW    = 32;
  localparam int YearInW = 14;
  localparam int OutW    = 34;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int MsW     = 10;

  // Divider remainder and divisor width, residue of year mod 400, span width
  localparam int RemW  = 18;
  localparam int ResW  = 9;
  localparam int ResW1 = ResW + 1;
  localparam int SpanW = 17;

  localparam int MsPerSec      = 1000;
  localparam int SecPerMin     = 60;
  localparam int MinPerHour    = 60;
  localparam int HourPerDay    = 24;
  localparam int DaysPerCycle  = 146097;
  localparam int YearsPerCycle = 400;
  localparam int YearsPerCent  = 100;
  localparam int YearsPerQuad  = 4;
  localparam int DaysYear      = 365;
  localparam int DaysQuad      = 1461;
  localparam int DaysCent      = 36524;
  localparam int LateYear      = 4000;
  localparam int DaysLeapYear  = 366;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_MS,
    OP_SET_MS,
    OP_DIV_SEC,
    OP_SET_SEC,
    OP_DIV_MIN,
    OP_SET_MIN,
    OP_DIV_HR,
    OP_SET_HR,
    OP_DIV_DAY,
    OP_SET_DAY,
    OP_DIV_YR,
    OP_SET_YR,
    OP_CENT,
    OP_QUAD,
    OP_YEAR,
    OP_LATE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    CND_NEXT,  // always advance
    CND_IN,    // hold until an input item is taken
    CND_DIV,   // hold until the divider is done
    CND_OUT,   // hold until the output register is free, then jump
    CND_MODE,  // jump when mode 1
    CND_FIT    // jump while the block subtraction fits
  } cond_e;

  localparam int StepW    = 5;
  localparam int NumSteps = 19;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepLoad = StepW'(0);
  localparam step_t StepCent = StepW'(14);
  localparam step_t StepQuad = StepW'(15);
  localparam step_t StepYear = StepW'(16);
  localparam step_t StepEmit = StepW'(18);
  localparam step_t StepLast = StepW'(NumSteps - 1);

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic mode;
    logic fit;
    logic out_free;
  } stat_t;

  // Program: carry ms -> s -> min -> h -> day; in mode 0, then split days into years.
  localparam uword_t Ucode [NumSteps] = '{
    '{OP_LOAD,    CND_IN,   StepLoad},
    '{OP_DIV_MS,  CND_NEXT, StepLoad},
    '{OP_SET_MS,  CND_DIV,  StepLoad},
    '{OP_DIV_SEC, CND_NEXT, StepLoad},
    '{OP_SET_SEC, CND_DIV,  StepLoad},
    '{OP_DIV_MIN, CND_NEXT, StepLoad},
    '{OP_SET_MIN, CND_DIV,  StepLoad},
    '{OP_DIV_HR,  CND_NEXT, StepLoad},
    '{OP_SET_HR,  CND_DIV,  StepLoad},
    '{OP_NOP,     CND_MODE, StepEmit},
    '{OP_DIV_DAY, CND_NEXT, StepLoad},
    '{OP_SET_DAY, CND_DIV,  StepLoad},
    '{OP_DIV_YR,  CND_NEXT, StepLoad},
    '{OP_SET_YR,  CND_DIV,  StepLoad},
    '{OP_CENT,    CND_FIT,  StepCent},
    '{OP_QUAD,    CND_FIT,  StepQuad},
    '{OP_YEAR,    CND_FIT,  StepYear},
    '{OP_LATE,    CND_NEXT, StepLoad},
    '{OP_EMIT,    CND_OUT,  StepLoad}
  };

  // r is the year mod 400
  function automatic logic is_century(logic [ResW-1:0] r);
    return (r == ResW'(YearsPerCent)) || (r == ResW'(2 * YearsPerCent)) ||
           (r == ResW'(3 * YearsPerCent));
  endfunction

  function automatic logic [SpanW-1:0] year_len(logic [ResW-1:0] r);
    logic leap;
    leap = (r[1:0] == 2'b00) && !is_century(r);
    return SpanW'(DaysYear) + SpanW'(leap);
  endfunction

  // Four years from r hold one multiple of four; short when it is a
  // century that is not a multiple of 400.
  function automatic logic [SpanW-1:0] span_quad(logic [ResW-1:0] r);
    logic short_span;
    short_span = (r >= ResW'(YearsPerCent - 3) && r <= ResW'(YearsPerCent)) ||
                 (r >= ResW'(2 * YearsPerCent - 3) && r <= ResW'(2 * YearsPerCent)) ||
                 (r >= ResW'(3 * YearsPerCent - 3) && r <= ResW'(3 * YearsPerCent));
    return SpanW'(DaysQuad) - SpanW'(short_span);
  endfunction

  // A hundred years from r hold one century; long when it is a multiple of 400.
  function automatic logic [SpanW-1:0] span_cent(logic [ResW-1:0] r);
    logic long_span;
    long_span = (r == '0) || (r > ResW'(3 * YearsPerCent));
    return SpanW'(DaysCent) + SpanW'(long_span);
  endfunction

  function automatic logic [ResW-1:0] res_add(logic [ResW-1:0] r, logic [ResW-1:0] inc);
    logic [ResW1-1:0] s;
    s = {1'b0, r} + {1'b0, inc};
    if (s >= ResW1'(YearsPerCycle)) begin
      s = s - ResW1'(YearsPerCycle);
    end
    return s[ResW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/ctn_if.sv
// ----------------------------------------------------------------------------
// ctn_if
// Valid/ready channels for time items entering and leaving the normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctn_in_if;
  import ctn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [YearInW-1:0]  year_in;
  logic signed [RawW-1:0]     day_in;
  logic signed [RawW-1:0]     hour_in;
  logic signed [RawW-1:0]     minute_in;
  logic signed [RawW-1:0]     second_in;
  logic signed [RawW-1:0]     milli_in;

  modport source (
    output valid, mode, year_in, day_in, hour_in, minute_in, second_in, milli_in,
    input  ready
  );

  modport sink (
    input  valid, mode, year_in, day_in, hour_in, minute_in, second_in, milli_in,
    output ready
  );
endinterface

interface ctn_out_if;
  import ctn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OutW-1:0]   year_out;
  logic signed [OutW-1:0]   day_out;
  logic        [HourW-1:0]  hour_out;
  logic        [MinW-1:0]   minute_out;
  logic        [SecW-1:0]   second_out;
  logic        [MsW-1:0]    milli_out;

  modport source (
    output valid, year_out, day_out, hour_out, minute_out, second_out, milli_out,
    input  ready
  );

  modport sink (
    input  valid, year_out, day_out, hour_out, minute_out, second_out, milli_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/ctn_div.sv
// ----------------------------------------------------------------------------
// ctn_div
// Floor divider of a signed word by a small positive constant, radix 16:
// four restoring steps per cycle, one quotient digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctn_div #(
  parameter int AW = 34
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [AW-1:0]             dividend_i,
  input  logic [ctn_pkg::RemW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [AW-1:0]             quo_o,
  output logic [ctn_pkg::RemW-1:0]  rem_o
);
  import ctn_pkg::*;

  localparam int DW     = ((AW + 3) / 4) * 4;
  localparam int Digits = DW / 4;
  localparam int CntW   = $clog2(Digits + 1);

  logic [DW-1:0]   num_q, quo_q;
  logic [RemW-1:0] rem_q, dvs_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic            neg_q;
  logic [AW-1:0]   mag;
  logic [RemW:0]   trial;
  logic [RemW-1:0] part;
  logic [3:0]      digit;

  // A negative dividend a is divided as ~a = -a-1; quotient and
  // remainder are folded back below.
  assign mag = dividend_i[AW-1] ? ~dividend_i : dividend_i;

  always_comb begin
    part  = rem_q;
    digit = '0;
    trial = '0;
    for (int i = 0; i < 4; i++) begin
      trial = {part, num_q[DW-1-i]};
      if (trial >= {1'b0, dvs_q}) begin
        trial        = trial - {1'b0, dvs_q};
        digit[3-i]   = 1'b1;
      end
      part = trial[RemW-1:0];
    end
    rem_d = part;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
      dvs_q <= '0;
      neg_q <= 1'b0;
      num_q <= '0;
      quo_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(Digits);
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[AW-1];
      num_q <= DW'(mag);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
      rem_q <= rem_d;
      num_q <= {num_q[DW-5:0], 4'b0000};
      quo_q <= {quo_q[DW-5:0], digit};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = neg_q ? ~quo_q[AW-1:0] : quo_q[AW-1:0];
  assign rem_o  = neg_q ? (dvs_q - RemW'(1) - rem_q) : rem_q;

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("divider remainder reached the divisor");

endmodule

`default_nettype wire

FILE: src/ctn_dp.sv
// ----------------------------------------------------------------------------
// ctn_dp
// Datapath: field registers, year residue, block-span subtraction, late-year
// substitution and the output register, all steered by the control word.
// ----------------------------------------------------------------------------
`default_nettype none

module ctn_dp #(
  parameter int FIELD_WIDTH = ctn_pkg::FieldWidthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctn_pkg::ctrl_t  ctrl_i,
  output ctn_pkg::stat_t  stat_o,
  ctn_in_if.sink          in_i,
  ctn_out_if.source       out_o
);
  import ctn_pkg::*;

  // Wide enough for every carry sum and for a day count below 146097
  localparam int AW = (FIELD_WIDTH + 2 > 19) ? FIELD_WIDTH + 2 : 19;
  localparam int NumFld = 5;
  localparam int IxDay  = 0;
  localparam int IxHour = 1;
  localparam int IxMin  = 2;
  localparam int IxSec  = 3;
  localparam int IxMs   = 4;

  logic [RawW-1:0] raw [NumFld];
  logic [AW-1:0]   ext [NumFld];

  logic            mode_q;
  logic [AW-1:0]   year_q, day_q, hr_q, min_q, sec_q, ms_q;
  logic [ResW-1:0] res_q;

  logic            div_start, div_busy;
  logic [AW-1:0]   div_a, div_quo;
  logic [RemW-1:0] div_d, div_rem;

  logic [SpanW-1:0] span;
  logic             fit, late, emit;

  logic                   out_valid_q;
  logic [OutW-1:0]        yr_out_q, day_out_q;
  logic [HourW-1:0]       hr_out_q;
  logic [MinW-1:0]        min_out_q;
  logic [SecW-1:0]        sec_out_q;
  logic [MsW-1:0]         ms_out_q;
  logic [AW+OutW-1:0]     yr_ext, day_ext;

  assign raw[IxDay]  = in_i.day_in;
  assign raw[IxHour] = in_i.hour_in;
  assign raw[IxMin]  = in_i.minute_in;
  assign raw[IxSec]  = in_i.second_in;
  assign raw[IxMs]   = in_i.milli_in;

  // Fields are read as FIELD_WIDTH-bit signed; wider than the port, non-negative
  for (genvar g = 0; g < NumFld; g++) begin : g_ext
    if (FIELD_WIDTH <= RawW) begin : g_sext
      assign ext[g] = AW'($signed(raw[g][FIELD_WIDTH-1:0]));
    end else begin : g_zext
      assign ext[g] = AW'(raw[g]);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = ms_q;
    div_d     = RemW'(MsPerSec);
    unique case (ctrl_i.op)
      OP_DIV_MS: begin
        div_start = ctrl_i.go;
      end
      OP_DIV_SEC: begin
        div_start = ctrl_i.go;
        div_a     = sec_q;
        div_d     = RemW'(SecPerMin);
      end
      OP_DIV_MIN: begin
        div_start = ctrl_i.go;
        div_a     = min_q;
        div_d     = RemW'(MinPerHour);
      end
      OP_DIV_HR: begin
        div_start = ctrl_i.go;
        div_a     = hr_q;
        div_d     = RemW'(HourPerDay);
      end
      OP_DIV_DAY: begin
        div_start = ctrl_i.go;
        div_a     = day_q;
        div_d     = RemW'(DaysPerCycle);
      end
      OP_DIV_YR: begin
        div_start = ctrl_i.go;
        div_a     = year_q;
        div_d     = RemW'(YearsPerCycle);
      end
      default: ;
    endcase
  end

  ctn_div #(
    .AW (AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    unique case (ctrl_i.op)
      OP_CENT: span = span_cent(res_q);
      OP_QUAD: span = span_quad(res_q);
      default: span = year_len(res_q);
    endcase
  end

  // Day is non-negative once the 400-year split is done
  assign fit  = (day_q >= AW'(span));
  assign late = ($signed(year_q) >= $signed(AW'(LateYear)));
  assign emit = ctrl_i.go && (ctrl_i.op == OP_EMIT);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      unique case (ctrl_i.op)
        OP_LOAD: begin
          mode_q <= in_i.mode;
          year_q <= AW'($signed(in_i.year_in));
          day_q  <= ext[IxDay];
          hr_q   <= ext[IxHour];
          min_q  <= ext[IxMin];
          sec_q  <= ext[IxSec];
          ms_q   <= ext[IxMs];
        end
        OP_SET_MS: begin
          ms_q  <= AW'(div_rem);
          sec_q <= sec_q + div_quo;
        end
        OP_SET_SEC: begin
          sec_q <= AW'(div_rem);
          min_q <= min_q + div_quo;
        end
        OP_SET_MIN: begin
          min_q <= AW'(div_rem);
          hr_q  <= hr_q + div_quo;
        end
        OP_SET_HR: begin
          hr_q  <= AW'(div_rem);
          day_q <= day_q + div_quo;
        end
        OP_SET_DAY: begin
          // year += 400 * quotient
          day_q  <= AW'(div_rem);
          year_q <= year_q + (div_quo << 8) + (div_quo << 7) + (div_quo << 4);
        end
        OP_SET_YR: begin
          res_q <= div_rem[ResW-1:0];
        end
        OP_CENT: begin
          if (fit) begin
            day_q  <= day_q - AW'(span);
            year_q <= year_q + AW'(YearsPerCent);
            res_q  <= res_add(res_q, ResW'(YearsPerCent));
          end
        end
        OP_QUAD: begin
          if (fit) begin
            day_q  <= day_q - AW'(span);
            year_q <= year_q + AW'(YearsPerQuad);
            res_q  <= res_add(res_q, ResW'(YearsPerQuad));
          end
        end
        OP_YEAR: begin
          if (fit) begin
            day_q  <= day_q - AW'(span);
            year_q <= year_q + AW'(1);
            res_q  <= res_add(res_q, ResW'(1));
          end
        end
        OP_LATE: begin
          if (late) begin
            year_q <= '0;
            day_q  <= AW'(1);
            hr_q   <= '0;
            min_q  <= '0;
            sec_q  <= '0;
            ms_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign yr_ext  = {{OutW{year_q[AW-1]}}, year_q};
  assign day_ext = {{OutW{day_q[AW-1]}}, day_q};

  always_ff @(posedge clk_i) begin
    if (emit) begin
      yr_out_q  <= yr_ext[OutW-1:0];
      day_out_q <= day_ext[OutW-1:0];
      hr_out_q  <= hr_q[HourW-1:0];
      min_out_q <= min_q[MinW-1:0];
      sec_out_q <= sec_q[SecW-1:0];
      ms_out_q  <= ms_q[MsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.year_out   = yr_out_q;
  assign out_o.day_out    = day_out_q;
  assign out_o.hour_out   = hr_out_q;
  assign out_o.minute_out = min_out_q;
  assign out_o.second_out = sec_out_q;
  assign out_o.milli_out  = ms_out_q;

  assign stat_o.busy     = div_busy;
  assign stat_o.mode     = mode_q;
  assign stat_o.fit      = fit;
  assign stat_o.out_free = !out_valid_q || out_o.ready;

  a_emit_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (hr_q < AW'(HourPerDay)) && (min_q < AW'(MinPerHour)) &&
             (sec_q < AW'(SecPerMin)) && (ms_q < AW'(MsPerSec)))
    else $error("time field out of range at result load");

  a_emit_day_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !mode_q) |-> (day_q < AW'(DaysLeapYear)))
    else $error("day of year out of range at result load");

  a_div_idle_on_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

FILE: src/ctn_seq.sv
// ----------------------------------------------------------------------------
// ctn_seq
// Microcode sequencer: step counter, program table lookup and conditional
// jumps; issues one control word per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ctn_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ctn_pkg::stat_t  stat_i,
  output ctn_pkg::ctrl_t  ctrl_o,
  output logic            in_ready_o
);
  import ctn_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;
  logic   go, jump;

  assign uw = Ucode[step_q];

  always_comb begin
    unique case (uw.cond)
      CND_IN:  go = in_valid_i;
      CND_DIV: go = !stat_i.busy;
      CND_OUT: go = stat_i.out_free;
      default: go = 1'b1;
    endcase
  end

  assign jump = ((uw.cond == CND_MODE) && stat_i.mode) ||
                ((uw.cond == CND_FIT) && stat_i.fit) ||
                (uw.cond == CND_OUT);

  always_comb begin
    if (!go) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepLoad;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.go   = go;
  assign in_ready_o  = (uw.cond == CND_IN);

  a_step_in_program : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast)
    else $error("step counter left the program");

endmodule

`default_nettype wire

FILE: src/calendar_time_normalizer.sv
// Mode 1 carries ms -> s -> min -> h -> day only; mode 0 then also splits the days
// into years by 400-year cycles and 100/4/1-year blocks and applies the late-year
// substitution. Throughput: one item at a time; one radix-16 divider is shared by
// all carries and splits, and the next item is taken while the last result waits
// at the output.
// Reset: asynchronous, active low; program returns to the load step, no result.
// ----------------------------------------------------------------------------
// calendar_time_normalizer
// Normalizes year, day, hour, minute, second and millisecond fields with
// floor carries and Gregorian year lengths, under a microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_time_normalizer #(
  parameter int FIELD_WIDTH = ctn_pkg::FieldWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctn_in_if.sink     in_i,
  ctn_out_if.source  out_o
);
  import ctn_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  ctn_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready)
  );

  assign in_i.ready = in_ready;

  ctn_dp #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
